/* rtl/sle_pkg.sv */
// Shared constants and types for the serial line editor.
`default_nettype none
package sle_pkg;

    // Default line store size in bytes
    localparam int LINE_CAPACITY_DEF = 128;

    // Command modes
    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_TAKE = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_echo;
        logic       last;
        logic       line_ready;
        logic [7:0] line_count;
    } sle_beat_t;

endpackage
`default_nettype wire

/* rtl/sle_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; rdata holds when re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/sle_edit.sv */
// Line state, command decode, line store and result beat sequencing.
`default_nettype none
module sle_edit #(
    parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       mode,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [6:0]       read_index,
    output logic                  beat_valid,
    input  wire logic             beat_ready,
    output sle_pkg::sle_beat_t    beat
);
    import sle_pkg::*;

    localparam int AW  = $clog2(LINE_CAPACITY);
    localparam int LW  = $clog2(LINE_CAPACITY + 1);
    localparam int CW  = (LW > 7) ? LW : 7;
    localparam int NW  = (LW > 8) ? LW : 8;
    localparam logic [LW-1:0] CAP = LW'(LINE_CAPACITY);

    typedef enum logic [1:0] {
        KIND_STATUS,
        KIND_ECHO,
        KIND_READ,
        KIND_BS
    } kind_t;

    logic [LW-1:0] line_len_reg, line_len_next;
    logic          ready_flag_reg, ready_flag_next;

    logic          s1_valid_reg, s1_valid_next;
    kind_t         s1_kind_reg, s1_kind_next;
    logic [7:0]    s1_byte_reg, s1_byte_next;
    logic          s1_hit_reg, s1_hit_next;
    logic          s1_ready_reg;
    logic [7:0]    s1_count_reg;
    logic [1:0]    s1_step_reg, s1_step_next;

    logic          accept;
    logic          wr_en;
    logic [CW-1:0] idx_ext;
    logic [NW-1:0] len_ext;
    logic [7:0]    rd_data;
    logic          beat_last;
    logic          beat_fire;

    assign accept    = in_valid && in_ready;
    assign idx_ext   = CW'(read_index);
    assign len_ext   = NW'(line_len_next);
    assign beat_fire = beat_valid && beat_ready;
    assign beat_last = (s1_kind_reg != KIND_BS) || (s1_step_reg == 2'd2);
    assign in_ready  = !s1_valid_reg || (beat_ready && beat_last);

    // Decode the incoming item and compute the new line state
    always_comb
    begin
        line_len_next   = line_len_reg;
        ready_flag_next = ready_flag_reg;
        s1_kind_next    = KIND_STATUS;
        s1_byte_next    = rx_byte;
        s1_hit_next     = CW'(line_len_reg) > idx_ext;
        wr_en           = 1'b0;
        unique case (mode)
            MODE_RX:
            begin
                if (rx_byte == CH_LF || rx_byte == CH_CR)
                begin
                    if (line_len_reg != '0)
                    begin
                        ready_flag_next = 1'b1;
                    end
                end
                else if (rx_byte >= CH_SPACE && rx_byte < CH_DEL)
                begin
                    if (line_len_reg < CAP)
                    begin
                        wr_en         = accept;
                        line_len_next = line_len_reg + LW'(1);
                        s1_kind_next  = KIND_ECHO;
                    end
                end
                else if (rx_byte == CH_DEL || rx_byte == CH_BS)
                begin
                    if (line_len_reg != '0)
                    begin
                        line_len_next = line_len_reg - LW'(1);
                        s1_kind_next  = KIND_BS;
                    end
                end
            end
            MODE_READ:
            begin
                s1_kind_next = KIND_READ;
            end
            MODE_TAKE:
            begin
                line_len_next   = '0;
                ready_flag_next = 1'b0;
            end
            default:
            begin
                s1_kind_next = KIND_STATUS;
            end
        endcase
    end

    // Line store; a read always comes at a later edge than any write before it
    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (line_len_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (accept),
        .raddr (idx_ext[AW-1:0]),
        .rdata (rd_data)
    );

    // Stage control: load on accept, step through backspace beats
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_step_next  = s1_step_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_step_next  = 2'd0;
        end
        else if (beat_fire)
        begin
            if (beat_last)
            begin
                s1_valid_next = 1'b0;
            end
            else
            begin
                s1_step_next = s1_step_reg + 2'd1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= '0;
            ready_flag_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_step_reg    <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_step_reg  <= s1_step_next;
            if (accept)
            begin
                line_len_reg   <= line_len_next;
                ready_flag_reg <= ready_flag_next;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= s1_kind_next;
            s1_byte_reg  <= s1_byte_next;
            s1_hit_reg   <= s1_hit_next;
            s1_ready_reg <= ready_flag_next;
            s1_count_reg <= len_ext[7:0];
        end
    end

    // Beat formation
    assign beat_valid      = s1_valid_reg;
    assign beat.line_ready = s1_ready_reg;
    assign beat.line_count = s1_count_reg;
    assign beat.last       = beat_last;

    always_comb
    begin
        unique case (s1_kind_reg)
            KIND_ECHO:
            begin
                beat.out_byte = s1_byte_reg;
                beat.is_echo  = 1'b1;
            end
            KIND_READ:
            begin
                beat.out_byte = s1_hit_reg ? rd_data : 8'd0;
                beat.is_echo  = 1'b0;
            end
            KIND_BS:
            begin
                beat.out_byte = (s1_step_reg == 2'd1) ? CH_SPACE : CH_BS;
                beat.is_echo  = 1'b1;
            end
            default:
            begin
                beat.out_byte = 8'd0;
                beat.is_echo  = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/serial_line_editor.sv */
// Top level of the serial line editor: stream ports and output register.
//
//  channel   dir  beat contents
//  s_axis    in   mode, rx_byte, read_index
//  m_axis    out  out_byte, line_ready, line_count; is_echo on tuser; last on tlast
//
//  A new item may be taken as the last beat of the previous one leaves; a
//  backspace on a non-empty line gives the echo beats BS, space, BS from the
//  single result stage. Results pass through the result stage and then a
//  registered output. Reset clears the line length, ready flag and all valid
//  bits; the line store is not cleared. A stalled output holds its beat and
//  blocks input once the result stage is also full.
`default_nettype none
module serial_line_editor #(
    parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // mode[1:0], rx_byte[9:2], read_index[16:10]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_byte[7:0], line_ready[8], line_count[16:9]
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser    // is_echo[0]
);
    import sle_pkg::*;

    logic      beat_valid;
    logic      beat_ready;
    sle_beat_t beat;

    logic      out_valid_reg;
    sle_beat_t out_beat_reg;

    sle_edit #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_edit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .mode       (s_axis_tdata[1:0]),
        .rx_byte    (s_axis_tdata[9:2]),
        .read_index (s_axis_tdata[16:10]),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat       (beat)
    );

    assign beat_ready = !out_valid_reg || m_axis_tready;

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (beat_ready)
        begin
            out_valid_reg <= beat_valid;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (beat_valid && beat_ready)
        begin
            out_beat_reg <= beat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_beat_reg.line_count, out_beat_reg.line_ready,
                            out_beat_reg.out_byte};
    assign m_axis_tlast  = out_beat_reg.last;
    assign m_axis_tuser  = out_beat_reg.is_echo;

endmodule
`default_nettype wire

/* verif/serial_line_editor_tb.sv */
// Self-checking testbench for the serial line editor: directed table, then random line sessions.
`timescale 1ns / 1ps
module serial_line_editor_tb;
    import sle_pkg::*;

    localparam int         LINE_CAP       = LINE_CAPACITY_DEF;
    localparam logic [1:0] MODE_BAD       = 2'd3;
    localparam logic [7:0] CH_TILDE       = 8'd126;
    localparam logic [7:0] CH_X           = 8'd120;
    localparam int         RANDOM_ITEMS   = 250;
    localparam int         LONG_HOLD      = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 20;

    // One row of the directed table; exp is used only when typed is set
    typedef struct {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
        bit         typed;
        sle_beat_t  exp;
    } dir_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    // Predicted line state
    logic [7:0] typed_line [LINE_CAP];
    int         typed_len;
    bit         cmd_ready;
    sle_beat_t  pred_beats [3];

    sle_beat_t  pending_beats [$];
    dir_row_t   dir_rows [$];
    int         mismatches  = 0;
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         hold_asks   = 0;
    int         hold_served = 0;
    int         hold_left   = 0;
    int         phase_left  = 0;
    int         phase_kind  = 0;
    int         idle_cycles = 0;

    serial_line_editor #(
        .LINE_CAPACITY (LINE_CAP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // mode[1:0], rx_byte[9:2], read_index[16:10]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_byte[7:0], line_ready[8], line_count[16:9]
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)    // is_echo[0]
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one item to the predicted line; fills pred_beats, returns beat count
    function automatic int edit_line(input logic [1:0] mode, input logic [7:0] b,
                                     input logic [6:0] ix);
        logic [7:0] bytes [3];
        bit         echo;
        int         n;
        n = 1;
        echo = 1'b0;
        bytes[0] = 8'd0;
        case (mode)
            MODE_RX:
                if (b == CH_LF || b == CH_CR)
                begin
                    if (typed_len != 0)
                        cmd_ready = 1'b1;
                end
                else if (b >= CH_SPACE && b < CH_DEL)
                begin
                    // full line drops the byte silently
                    if (typed_len < LINE_CAP)
                    begin
                        typed_line[typed_len] = b;
                        typed_len++;
                        echo = 1'b1;
                        bytes[0] = b;
                    end
                end
                else if (b == CH_DEL || b == CH_BS)
                begin
                    if (typed_len != 0)
                    begin
                        typed_len--;
                        echo = 1'b1;
                        n = 3;
                        bytes[0] = CH_BS;
                        bytes[1] = CH_SPACE;
                        bytes[2] = CH_BS;
                    end
                end
            MODE_READ:
                if (ix < typed_len)
                    bytes[0] = typed_line[ix];
            MODE_TAKE:
            begin
                typed_len = 0;
                cmd_ready = 1'b0;
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++)
        begin
            pred_beats[k].out_byte   = bytes[k];
            pred_beats[k].is_echo    = echo;
            pred_beats[k].last       = (k == n - 1);
            pred_beats[k].line_ready = cmd_ready;
            pred_beats[k].line_count = 8'(typed_len);
        end
        return n;
    endfunction

    function automatic sle_beat_t status_beat(input logic [7:0] b, input logic echo,
                                              input logic rdy, input logic [7:0] cnt);
        sle_beat_t r;
        r.out_byte   = b;
        r.is_echo    = echo;
        r.last       = 1'b1;
        r.line_ready = rdy;
        r.line_count = cnt;
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] mode, input logic [7:0] b,
                                    input logic [6:0] ix, input bit typed,
                                    input sle_beat_t exp);
        dir_row_t row;
        row.mode       = mode;
        row.rx_byte    = b;
        row.read_index = ix;
        row.typed      = typed;
        row.exp        = exp;
        dir_rows.push_back(row);
    endfunction

    // Sender pacing: bursts of random length, random gaps; called at a falling edge
    task automatic pace();
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Offer one beat, wait for acceptance, log its expected results
    task automatic send_item(input logic [1:0] mode, input logic [7:0] b,
                             input logic [6:0] ix, input bit typed, input sle_beat_t exp);
        int n;
        pace();
        s_axis_tdata  <= {7'd0, ix, b, mode};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n = edit_line(mode, b, ix);
        if (typed)
            pending_beats.push_back(exp);
        else
            for (int k = 0; k < n; k++)
                pending_beats.push_back(pred_beats[k]);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send(input logic [1:0] mode, input logic [7:0] b, input logic [6:0] ix);
        send_item(mode, b, ix, 1'b0, '0);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [6:0] any_index();
        return 7'($urandom_range(0, 127));
    endfunction

    // Fill the line to capacity, overflow it, then edit and take it
    task automatic fill_session();
        send(MODE_TAKE, 8'($urandom), any_index());
        repeat (LINE_CAP + 3) send(MODE_RX, printable(), any_index());
        send(MODE_READ, 8'($urandom), 7'(LINE_CAP - 1));
        send(MODE_READ, 8'($urandom), 7'd0);
        send(MODE_RX, CH_BS, any_index());
        send(MODE_RX, printable(), any_index());
        send(MODE_RX, printable(), any_index());
        send(MODE_RX, CH_CR, any_index());
        send(MODE_READ, 8'($urandom), any_index());
        send(MODE_TAKE, 8'($urandom), any_index());
    endtask

    // Type a line with edits and noise, usually end it, maybe read it back, usually take it
    task automatic type_session();
        int n;
        int r;
        int top;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
                send(MODE_RX, printable(), any_index());
            else if (r < 88)
                send(MODE_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL, any_index());
            else if (r < 94)
                send(MODE_RX, $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                                   : 8'($urandom_range(0, 31)), any_index());
            else if (r < 97)
                send(MODE_READ, 8'($urandom), any_index());
            else
                send(MODE_BAD, 8'($urandom), any_index());
        end
        // line end; sometimes missing, sometimes more typing after it
        r = $urandom_range(0, 9);
        if (r != 0)
            send(MODE_RX, (r < 5) ? CH_CR : CH_LF, any_index());
        if ($urandom_range(0, 5) == 0)
            send(MODE_RX, printable(), any_index());
        repeat ($urandom_range(0, 3))
        begin
            top = (typed_len > 127) ? 127 : typed_len;
            send(MODE_READ, 8'($urandom),
                 ($urandom_range(0, 4) == 0) ? any_index() : 7'($urandom_range(0, top)));
        end
        if ($urandom_range(0, 7) != 0)
            send(MODE_TAKE, 8'($urandom), any_index());
    endtask

    // Result checker
    task automatic check_field(input string name, input int exp, input int act);
        if (exp != act)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        sle_beat_t got;
        sle_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_byte   = m_axis_tdata[7:0];
            got.is_echo    = m_axis_tuser[0];
            got.last       = m_axis_tlast;
            got.line_ready = m_axis_tdata[8];
            got.line_count = m_axis_tdata[16:9];
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("out_byte", want.out_byte, got.out_byte);
                check_field("is_echo", want.is_echo, got.is_echo);
                check_field("last", want.last, got.last);
                check_field("line_ready", want.line_ready, got.line_ready);
                check_field("line_count", want.line_count, got.line_count);
            end
        end
    end

    // Receiver: phases of full rate, random and sparse ready, plus requested long holds
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                phase_kind = $urandom_range(0, 2);
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            case (phase_kind)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= (phase_left % 4 == 0);
            endcase
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("serial_line_editor_tb failed");
            $finish;
        end
    end

    initial
    begin
        bit held;
        bit paused;
        bit filled;
        held   = 1'b0;
        paused = 1'b0;
        filled = 1'b0;
        typed_len = 0;
        cmd_ready = 1'b0;

        // Directed table: empty line, field extremes, ignored bytes, edits, take
        add_row(MODE_READ, 8'd0,     7'd0,   1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_RX,   CH_BS,    7'd0,   1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_RX,   CH_DEL,   7'd0,   1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_RX,   CH_CR,    7'd0,   1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_RX,   CH_LF,    7'd0,   1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_BAD,  8'd255,   7'd127, 1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_RX,   CH_SPACE, 7'd127, 1, status_beat(CH_SPACE, 1, 0, 8'd1));
        add_row(MODE_RX,   CH_TILDE, 7'd0,   1, status_beat(CH_TILDE, 1, 0, 8'd2));
        add_row(MODE_RX,   8'd0,     7'd0,   1, status_beat(8'd0, 0, 0, 8'd2));
        add_row(MODE_RX,   8'd31,    7'd0,   1, status_beat(8'd0, 0, 0, 8'd2));
        add_row(MODE_RX,   8'd128,   7'd0,   1, status_beat(8'd0, 0, 0, 8'd2));
        add_row(MODE_RX,   8'd255,   7'd0,   1, status_beat(8'd0, 0, 0, 8'd2));
        add_row(MODE_READ, 8'd255,   7'd0,   1, status_beat(CH_SPACE, 0, 0, 8'd2));
        add_row(MODE_READ, 8'd0,     7'd1,   1, status_beat(CH_TILDE, 0, 0, 8'd2));
        add_row(MODE_READ, 8'd0,     7'd2,   1, status_beat(8'd0, 0, 0, 8'd2));
        add_row(MODE_READ, 8'd0,     7'd127, 1, status_beat(8'd0, 0, 0, 8'd2));
        add_row(MODE_RX,   CH_CR,    7'd0,   1, status_beat(8'd0, 0, 1, 8'd2));
        add_row(MODE_RX,   CH_X,     7'd0,   1, status_beat(CH_X, 1, 1, 8'd3));
        add_row(MODE_RX,   CH_DEL,   7'd0,   0, '0);
        add_row(MODE_RX,   CH_BS,    7'd0,   0, '0);
        add_row(MODE_RX,   CH_LF,    7'd0,   0, '0);
        add_row(MODE_READ, 8'd0,     7'd0,   0, '0);
        add_row(MODE_TAKE, 8'd0,     7'd0,   1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_TAKE, 8'd255,   7'd127, 1, status_beat(8'd0, 0, 0, 8'd0));
        add_row(MODE_READ, 8'd255,   7'd127, 1, status_beat(8'd0, 0, 0, 8'd0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].mode, dir_rows[i].rx_byte, dir_rows[i].read_index,
                      dir_rows[i].typed, dir_rows[i].exp);

        // Random line sessions, with one long output hold and one full drain
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!held && items_sent > 40)
            begin
                hold_asks++;
                held = 1'b1;
            end
            if (!paused && items_sent > 200)
            begin
                drain();
                paused = 1'b1;
            end
            if (!filled && items_sent > 80)
            begin
                fill_session();
                filled = 1'b1;
            end
            else
                type_session();
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("serial_line_editor_tb passed");
        else
            $display("serial_line_editor_tb failed");
        $finish;
    end

endmodule

/* serial_line_editor.f */
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_edit.sv
rtl/serial_line_editor.sv
verif/serial_line_editor_tb.sv
